// File: src/pba_pkg.sv
package pba_pkg;

    // Block geometry. All are powers of two, so slot and time-slot extraction is bit selection.
    localparam int SAMPLES_PER_BLOCK  = 256;
    localparam int RING_BLOCKS        = 4;
    localparam int SOURCES            = 8;
    localparam int FULL_BLOCK_PACKETS = 2048;

    localparam int HDR_W     = 64;
    localparam int CNT_W     = 44;
    localparam int CNT_LSB   = 20;
    localparam int ID_W      = 8;
    localparam int SLOT_W    = $clog2(SAMPLES_PER_BLOCK);
    localparam int BLK_W     = $clog2(RING_BLOCKS);
    localparam int SPAN_W    = SLOT_W + BLK_W;
    localparam int PKT_CNT_W = 16;
    localparam int KIND_W    = 2;
    localparam int WARN_W    = 2;
    localparam int REASON_W  = 3;
    localparam int RES_DEPTH = 3;
    localparam int RES_IDX_W = $clog2(RES_DEPTH);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int TDATA_W    = 72;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DROP  = 2'd3;

    localparam logic [REASON_W-1:0] DROP_NONE    = 3'd0;
    localparam logic [REASON_W-1:0] DROP_RESYNC  = 3'd1;
    localparam logic [REASON_W-1:0] DROP_EARLY   = 3'd2;
    localparam logic [REASON_W-1:0] DROP_BAD_SRC = 3'd3;
    localparam logic [REASON_W-1:0] DROP_BAD_DST = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_XENGINE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_XENGINE_CHECK_ON = 8'd1;

    typedef enum logic [1:0] {
        CASE_NORMAL = 2'd0,
        CASE_CLOSE  = 2'd1,
        CASE_RESYNC = 2'd2,
        CASE_EARLY  = 2'd3
    } pkt_case_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BLK_W-1:0]    blk;
        logic [CNT_W-1:0]    count;
        logic [SLOT_W-1:0]   tslot;
        logic [ID_W-1:0]     src;
        logic                good;
        logic [WARN_W-1:0]   warn;
        logic [REASON_W-1:0] reason;
        logic                last;
    } result_t;

endpackage

// File: src/packet_block_assembler_core.sv
// Packet block assembler. Each transfer on the s_ side carries one 64-bit packet header
// (time count in bits 63..20, source F-engine ID in 15..8, destination X-engine ID in 7..0).
// For every header the block emits one to three results on the m_ side, in this order:
// a "block filled" and a "block initialised" result when the packet is two blocks ahead
// of the current block start, then a payload write or a drop for the packet itself; a
// packet three or more blocks ahead gives an init result for the resynchronized start and
// a drop; an early packet gives a single drop. m_tlast marks the final result of a header.
// Timing: the first result of a header is valid on m_tvalid in the cycle after the one in
// which the header leaves the read stage. The block takes a new header every cycle as
// long as each header yields one result and m_tready is high; a header with several
// results holds the output until its last result is sent, so sustained throughput is one
// result per cycle while m_tready is high. The per-block packet counts sit in a small
// synchronous memory with a registered read; each header does one read at acceptance and
// one write-back as it leaves the read stage, with forwarding from the last write-back.
// Valid bits clear the counts at reset, so there is no clearing pass and the block is ready
// right after reset. Configuration writes are always accepted (cfg_ready is tied high) and
// should only be issued while the block is idle.
module packet_block_assembler_core import pba_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [HDR_W-1:0]      s_tdata,   // header word[63:0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0 up: block_index[1:0], count_value[45:2], time_slot[53:46],
    // source_index[61:54], block_full[62], order_warning[64:63], drop_reason[67:65],
    // zero padding[71:68].
    output logic [TDATA_W-1:0]    m_tdata,
    output logic [KIND_W-1:0]     m_tuser,   // entry_kind[1:0]
    output logic                  m_tlast,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [CNT_W:0]   TWO_BLOCKS   = (CNT_W+1)'(2 * SAMPLES_PER_BLOCK);
    localparam logic [CNT_W:0]   THREE_BLOCKS = (CNT_W+1)'(3 * SAMPLES_PER_BLOCK);
    localparam logic [CNT_W-1:0] BLOCK_CNT    = CNT_W'(SAMPLES_PER_BLOCK);
    localparam logic [CNT_W-1:0] SPAN_CNT     = CNT_W'(SAMPLES_PER_BLOCK * RING_BLOCKS);
    localparam logic [PKT_CNT_W-1:0] FULL_CNT = PKT_CNT_W'(FULL_BLOCK_PACKETS);
    localparam logic [PKT_CNT_W-1:0] CNT_SAT  = {PKT_CNT_W{1'b1}};
    localparam logic [ID_W-1:0]      SRC_LIM  = ID_W'(SOURCES);

    // Configuration registers.
    logic [ID_W-1:0] expected_xengine_reg;
    logic            check_on_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_xengine_reg <= '0;
            check_on_reg         <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_EXPECTED_XENGINE) begin
                expected_xengine_reg <= cfg_data[ID_W-1:0];
            end else if (cfg_index == CFG_XENGINE_CHECK_ON) begin
                check_on_reg <= cfg_data[0];
            end
        end
    end

    // Ring state kept in registers; it is updated at the transfer of each header so the
    // next header is classified against up-to-date values.
    logic [CNT_W-1:0] start_reg, start_next;
    logic [BLK_W-1:0] cur_block_reg, cur_block_next;
    logic [BLK_W-1:0] last_filled_reg, last_filled_next;

    // Classification of the incoming header.
    logic             s_xfer;
    logic [CNT_W-1:0] hdr_cnt;
    logic [ID_W-1:0]  hdr_src;
    logic [ID_W-1:0]  hdr_dst;
    logic [BLK_W-1:0] hdr_blk;
    logic [CNT_W:0]   cnt_delta;
    logic             is_early, is_far, is_close;
    logic [BLK_W-1:0] fill_blk;
    logic [CNT_W-1:0] resync_start;
    logic [WARN_W-1:0] warn;
    pkt_case_t        hdr_case;

    assign s_xfer    = s_tvalid && s_tready;
    assign hdr_cnt   = s_tdata[CNT_LSB +: CNT_W];
    assign hdr_src   = s_tdata[ID_W +: ID_W];
    assign hdr_dst   = s_tdata[ID_W-1:0];
    assign hdr_blk   = hdr_cnt[SLOT_W +: BLK_W];
    assign cnt_delta = {1'b0, hdr_cnt} - {1'b0, start_reg};
    assign is_early  = cnt_delta[CNT_W];
    assign is_far    = !cnt_delta[CNT_W] && (cnt_delta >= THREE_BLOCKS);
    assign is_close  = !cnt_delta[CNT_W] && (cnt_delta >= TWO_BLOCKS) && !is_far;
    assign fill_blk  = start_reg[SLOT_W +: BLK_W];

    // Next start after a resync: the packet count rounded down to a whole ring, plus one ring.
    assign resync_start = {hdr_cnt[CNT_W-1:SPAN_W], {SPAN_W{1'b0}}} + SPAN_CNT;

    assign warn[0] = ((last_filled_reg + BLK_W'(1)) != fill_blk);
    assign warn[1] = (fill_blk != cur_block_reg);

    always_comb begin
        if (is_early) begin
            hdr_case = CASE_EARLY;
        end else if (is_far) begin
            hdr_case = CASE_RESYNC;
        end else if (is_close) begin
            hdr_case = CASE_CLOSE;
        end else begin
            hdr_case = CASE_NORMAL;
        end
    end

    always_comb begin
        start_next       = start_reg;
        cur_block_next   = cur_block_reg;
        last_filled_next = last_filled_reg;
        if (s_xfer) begin
            case (hdr_case)
                CASE_CLOSE: begin
                    start_next       = start_reg + BLOCK_CNT;
                    cur_block_next   = cur_block_reg + BLK_W'(1);
                    last_filled_next = fill_blk;
                end
                CASE_RESYNC: begin
                    start_next = resync_start;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg       <= '0;
            cur_block_reg   <= '0;
            last_filled_reg <= BLK_W'(RING_BLOCKS - 1);
        end else begin
            start_reg       <= start_next;
            cur_block_reg   <= cur_block_next;
            last_filled_reg <= last_filled_next;
        end
    end

    // Read stage: holds a header while its count read completes.
    logic             r_valid_reg;
    pkt_case_t        r_case_reg;
    logic [CNT_W-1:0] r_cnt_reg;
    logic [ID_W-1:0]  r_src_reg;
    logic [BLK_W-1:0] r_blk_reg;
    logic [BLK_W-1:0] r_fill_blk_reg;
    logic [CNT_W-1:0] r_fill_count_reg;
    logic [WARN_W-1:0] r_warn_reg;
    logic             r_bad_src_reg;
    logic             r_bad_dst_reg;
    logic [BLK_W-1:0] r_init_blk_reg;
    logic [CNT_W-1:0] r_init_count_reg;
    logic [BLK_W-1:0] r_rd_addr_reg;
    logic [BLK_W-1:0] r_wr_addr_reg;

    logic             r_advance;
    logic             o_valid_reg;
    logic             o_done;
    logic [BLK_W-1:0] rd_addr;

    // The fill result needs the count of the block being closed; otherwise the packet's own.
    assign rd_addr   = (hdr_case == CASE_CLOSE) ? fill_blk : hdr_blk;
    assign r_advance = r_valid_reg && (!o_valid_reg || o_done);
    assign s_tready  = !r_valid_reg || r_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            r_valid_reg <= 1'b1;
        end else if (r_advance) begin
            r_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            r_case_reg       <= hdr_case;
            r_cnt_reg        <= hdr_cnt;
            r_src_reg        <= hdr_src;
            r_blk_reg        <= hdr_blk;
            r_fill_blk_reg   <= fill_blk;
            r_fill_count_reg <= start_reg;
            r_warn_reg       <= warn;
            r_bad_src_reg    <= (hdr_src >= SRC_LIM);
            r_bad_dst_reg    <= check_on_reg && (hdr_dst != expected_xengine_reg);
            r_rd_addr_reg    <= rd_addr;
            if (hdr_case == CASE_RESYNC) begin
                r_init_blk_reg   <= resync_start[SLOT_W +: BLK_W];
                r_init_count_reg <= resync_start;
                r_wr_addr_reg    <= cur_block_reg;
            end else begin
                r_init_blk_reg   <= hdr_blk;
                r_init_count_reg <= {hdr_cnt[CNT_W-1:SLOT_W], {SLOT_W{1'b0}}};
                r_wr_addr_reg    <= hdr_blk;
            end
        end
    end

    // Packet count memory with valid bits standing in for the reset clear.
    logic [PKT_CNT_W-1:0]   cnt_mem [RING_BLOCKS];
    logic [RING_BLOCKS-1:0] entry_valid_reg;
    logic [PKT_CNT_W-1:0]   rd_data_reg;
    logic                   rd_valid_reg;
    logic                   wr_en;
    logic [PKT_CNT_W-1:0]   wr_data;
    logic                   fwd_valid_reg;
    logic [BLK_W-1:0]       fwd_addr_reg;
    logic [PKT_CNT_W-1:0]   fwd_data_reg;
    logic [PKT_CNT_W-1:0]   eff_count;

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            rd_data_reg <= cnt_mem[rd_addr];
        end
        if (wr_en) begin
            cnt_mem[r_wr_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
        end else begin
            if (s_xfer) begin
                rd_valid_reg <= entry_valid_reg[rd_addr];
            end
            if (wr_en) begin
                entry_valid_reg[r_wr_addr_reg] <= 1'b1;
                fwd_valid_reg                  <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_addr_reg <= r_wr_addr_reg;
            fwd_data_reg <= wr_data;
        end
    end

    // The latest write-back may have landed in the same cycle as the read was issued.
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == r_rd_addr_reg)) begin
            eff_count = fwd_data_reg;
        end else if (rd_valid_reg) begin
            eff_count = rd_data_reg;
        end else begin
            eff_count = '0;
        end
    end

    always_comb begin
        wr_en   = r_advance && (r_case_reg != CASE_EARLY);
        case (r_case_reg)
            CASE_CLOSE:  wr_data = PKT_CNT_W'(1);
            CASE_RESYNC: wr_data = '0;
            default:     wr_data = (eff_count == CNT_SAT) ? eff_count
                                                           : eff_count + PKT_CNT_W'(1);
        endcase
    end

    // Build the result list of the header in the read stage.
    result_t res_next [RES_DEPTH];
    result_t final_res;
    result_t init_res;

    always_comb begin
        final_res       = '0;
        final_res.blk   = r_blk_reg;
        final_res.count = r_cnt_reg;
        final_res.last  = 1'b1;
        if (r_bad_src_reg) begin
            final_res.kind   = KIND_DROP;
            final_res.reason = DROP_BAD_SRC;
        end else if (r_bad_dst_reg) begin
            final_res.kind   = KIND_DROP;
            final_res.reason = DROP_BAD_DST;
        end else begin
            final_res.kind  = KIND_WRITE;
            final_res.tslot = r_cnt_reg[SLOT_W-1:0];
            final_res.src   = r_src_reg;
        end

        init_res       = '0;
        init_res.kind  = KIND_INIT;
        init_res.blk   = r_init_blk_reg;
        init_res.count = r_init_count_reg;

        for (int i = 0; i < RES_DEPTH; i++) begin
            res_next[i] = '0;
        end

        case (r_case_reg)
            CASE_CLOSE: begin
                res_next[0].kind  = KIND_FILL;
                res_next[0].blk   = r_fill_blk_reg;
                res_next[0].count = r_fill_count_reg;
                res_next[0].good  = (eff_count == FULL_CNT);
                res_next[0].warn  = r_warn_reg;
                res_next[1]       = init_res;
                res_next[2]       = final_res;
            end
            CASE_RESYNC: begin
                res_next[0]        = init_res;
                res_next[1].kind   = KIND_DROP;
                res_next[1].blk    = r_blk_reg;
                res_next[1].count  = r_cnt_reg;
                res_next[1].reason = DROP_RESYNC;
                res_next[1].last   = 1'b1;
            end
            CASE_EARLY: begin
                res_next[0].kind   = KIND_DROP;
                res_next[0].blk    = r_blk_reg;
                res_next[0].count  = r_cnt_reg;
                res_next[0].reason = DROP_EARLY;
                res_next[0].last   = 1'b1;
            end
            default: begin
                res_next[0] = final_res;
            end
        endcase
    end

    // Output buffer: the results of one header, sent one per transfer.
    result_t              o_res_reg [RES_DEPTH];
    logic [RES_IDX_W-1:0] o_ptr_reg;
    result_t              cur_res;

    assign cur_res  = o_res_reg[o_ptr_reg];
    assign m_tvalid = o_valid_reg;
    assign m_tuser  = cur_res.kind;
    assign m_tlast  = cur_res.last;
    assign m_tdata  = {4'b0, cur_res.reason, cur_res.warn, cur_res.good, cur_res.src,
                       cur_res.tslot, cur_res.count, cur_res.blk};
    assign o_done   = m_tvalid && m_tready && cur_res.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
            o_ptr_reg   <= '0;
        end else if (r_advance) begin
            o_valid_reg <= 1'b1;
            o_ptr_reg   <= '0;
        end else if (m_tvalid && m_tready) begin
            if (cur_res.last) begin
                o_valid_reg <= 1'b0;
            end else begin
                o_ptr_reg <= o_ptr_reg + RES_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r_advance) begin
            for (int i = 0; i < RES_DEPTH; i++) begin
                o_res_reg[i] <= res_next[i];
            end
        end
    end

    // A header always enters the read stage on the cycle after its transfer.
    a_accept_to_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> r_valid_reg)
        else $error("accepted header did not reach the read stage");

    // A filled block is always followed directly by the init of the next block.
    a_fill_then_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && (m_tuser == KIND_FILL)) |=>
            (m_tvalid && (m_tuser == KIND_INIT) && !m_tlast))
        else $error("fill result not followed by init result");

    // The third result of a header is always its last one.
    a_third_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (o_ptr_reg == RES_IDX_W'(RES_DEPTH - 1))) |-> m_tlast)
        else $error("result list runs past its end");

    // The current block only moves when a header closes a block.
    a_block_moves_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (cur_block_reg != $past(cur_block_reg))) |->
            $past(s_xfer && (hdr_case == CASE_CLOSE)))
        else $error("current block changed without a close");

    // Count write-back happens only as a header leaves the read stage.
    a_write_in_order: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> o_valid_reg)
        else $error("count write-back without a result list");

endmodule
